>>> hdl/mailbox_hmac_sha256_verify_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the verify unit modules.
// ---------------------------------------------------------------------------
`ifndef MAILBOX_HMAC_SHA256_VERIFY_UNIT_ASSERT_SVH
`define MAILBOX_HMAC_SHA256_VERIFY_UNIT_ASSERT_SVH

// Asserts that an implication holds at every clock edge out of reset.
`define MHV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts that a condition implies another one on the next clock edge.
`define MHV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/mhv_pkg.sv
// ---------------------------------------------------------------------------
// mhv_pkg
// Shared types, constants and SHA-256 helper functions.
// ---------------------------------------------------------------------------
package mhv_pkg;

  localparam int unsigned NumKeyRegs = 4;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegKey0 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKey1 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKey2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegKey3 = 2'd3;

  localparam logic [31:0] IpadWord = 32'h3636_3636;
  localparam logic [31:0] OpadWord = 32'h5c5c_5c5c;
  localparam logic [31:0] PadBit   = 32'h8000_0000;
  localparam logic [31:0] InnerLen = 32'd640;
  localparam logic [31:0] OuterLen = 32'd768;

  // Which block the datapath loads into the message schedule.
  typedef enum logic [1:0] {
    BLK_INNER_KEY = 2'd0,
    BLK_MSG       = 2'd1,
    BLK_OUTER_KEY = 2'd2,
    BLK_DIGEST    = 2'd3
  } blk_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;   // latch the input request
    logic     load;      // load a block and chaining value
    blk_sel_t sel;
    logic     round;     // run one compression round
    logic     finish;    // add the working variables into the chaining value
    logic     keep_inner; // keep the chaining value as the inner digest
  } mhv_cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

  function automatic logic [255:0] start_h();
    start_h = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

endpackage

>>> hdl/mhv_ctrl.sv
// ---------------------------------------------------------------------------
// mhv_ctrl
// Sequencer for the four compressions of one HMAC check.
// ---------------------------------------------------------------------------
module mhv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mhv_pkg::mhv_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FINISH,
    S_DONE
  } state_t;

  state_t              state;
  logic [5:0]          rnd;
  mhv_pkg::blk_sel_t   blk;

  assign in_stall  = (state != S_IDLE) || out_valid;

  // Commands decoded from the current state.
  always_comb begin
    cmd            = '0;
    cmd.sel        = blk;
    cmd.capture    = (state == S_IDLE) && in_valid && !out_valid;
    cmd.load       = (state == S_LOAD);
    cmd.round      = (state == S_ROUND);
    cmd.finish     = (state == S_FINISH);
    cmd.keep_inner = (state == S_FINISH) && (blk == mhv_pkg::BLK_MSG);
  end

  // State, round counter and result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= '0;
      blk       <= mhv_pkg::BLK_INNER_KEY;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !out_valid) begin
            blk   <= mhv_pkg::BLK_INNER_KEY;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (blk == mhv_pkg::BLK_DIGEST) begin
            state <= S_DONE;
          end else begin
            blk   <= mhv_pkg::blk_sel_t'(blk + 2'd1);
            state <= S_LOAD;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "mailbox_hmac_sha256_verify_unit_assert.svh"
  `MHV_ASSERT_NEXT(a_round_starts_at_zero, clk, rst, state == S_LOAD, rnd == 6'd0)
  `MHV_ASSERT_NEXT(a_done_gives_valid, clk, rst, state == S_DONE, out_valid)
  `MHV_ASSERT_IMP(a_busy_stalls, clk, rst, state != S_IDLE, in_stall)

endmodule

>>> hdl/mhv_datapath.sv
// ---------------------------------------------------------------------------
// mhv_datapath
// Key store, message schedule window and one shared SHA-256 round unit.
// ---------------------------------------------------------------------------
module mhv_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mhv_pkg::mhv_cmd_t             cmd,
  input  logic                          cfg_we,
  input  logic [mhv_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [63:0]                   cfg_data,
  input  logic [127:0]                  msg,
  input  logic [255:0]                  given,
  output logic [255:0]                  tag,
  output logic                          ok
);

  logic [255:0] key;
  logic [127:0] msg_q;
  logic [255:0] given_q;
  logic [511:0] win;
  logic [511:0] win_next;
  logic [255:0] h;
  logic [255:0] inner;
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vhh;
  logic [5:0]   rnd;
  logic [511:0] blk_data;
  logic [31:0]  pad;
  logic [31:0]  w0, w1, w9, w14, s0, s1, t1, t2;

  // Configuration writes into the key store.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        mhv_pkg::RegKey0: key[255:192] <= cfg_data;
        mhv_pkg::RegKey1: key[191:128] <= cfg_data;
        mhv_pkg::RegKey2: key[127:64]  <= cfg_data;
        mhv_pkg::RegKey3: key[63:0]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block chosen for the next compression.
  always_comb begin
    pad = (cmd.sel == mhv_pkg::BLK_INNER_KEY) ? mhv_pkg::IpadWord : mhv_pkg::OpadWord;
    case (cmd.sel)
      mhv_pkg::BLK_MSG:
        blk_data = {msg_q, mhv_pkg::PadBit, 320'd0, mhv_pkg::InnerLen};
      mhv_pkg::BLK_DIGEST:
        blk_data = {inner, mhv_pkg::PadBit, 192'd0, mhv_pkg::OuterLen};
      default:
        blk_data = {key ^ {8{pad}}, {8{pad}}};
    endcase
  end

  // Schedule: the window shifts one word a round, the new word at the end.
  assign w0  = win[511:480];
  assign w1  = win[479:448];
  assign w9  = win[223:192];
  assign w14 = win[63:32];
  assign s0  = mhv_pkg::rotr(w1, 7) ^ mhv_pkg::rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = mhv_pkg::rotr(w14, 17) ^ mhv_pkg::rotr(w14, 19) ^ (w14 >> 10);
  assign win_next = {win[479:0], w0 + s0 + w9 + s1};

  // One compression round.
  assign t1 = vhh + (mhv_pkg::rotr(ve, 6) ^ mhv_pkg::rotr(ve, 11) ^ mhv_pkg::rotr(ve, 25))
            + ((ve & vf) ^ (~ve & vg)) + mhv_pkg::round_k(rnd) + w0;
  assign t2 = (mhv_pkg::rotr(va, 2) ^ mhv_pkg::rotr(va, 13) ^ mhv_pkg::rotr(va, 22))
            + ((va & vb) ^ (va & vc) ^ (vb & vc));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      msg_q   <= msg;
      given_q <= given;
    end
    if (cmd.load) begin
      win <= blk_data;
      rnd <= '0;
      if (cmd.sel == mhv_pkg::BLK_INNER_KEY || cmd.sel == mhv_pkg::BLK_OUTER_KEY) begin
        h <= mhv_pkg::start_h();
        {va, vb, vc, vd, ve, vf, vg, vhh} <= mhv_pkg::start_h();
      end else begin
        {va, vb, vc, vd, ve, vf, vg, vhh} <= h;
      end
    end
    if (cmd.round) begin
      win <= win_next;
      rnd <= rnd + 6'd1;
      {va, vb, vc, vd, ve, vf, vg, vhh} <= {t1 + t2, va, vb, vc, vd + t1, ve, vf, vg};
    end
    if (cmd.finish) begin
      h <= {h[255:224] + va, h[223:192] + vb, h[191:160] + vc, h[159:128] + vd,
            h[127:96] + ve, h[95:64] + vf, h[63:32] + vg, h[31:0] + vhh};
    end
    if (cmd.keep_inner) begin
      inner <= {h[255:224] + va, h[223:192] + vb, h[191:160] + vc, h[159:128] + vd,
                h[127:96] + ve, h[95:64] + vf, h[63:32] + vg, h[31:0] + vhh};
    end
  end

  assign tag = h;
  assign ok  = (h == given_q);

endmodule

>>> hdl/mailbox_hmac_sha256_verify_unit.sv
// Each request runs four 64-round compressions on the single round unit, one
// round a cycle; a new request is taken only after out_valid has been taken.
// Per compression: load, rounds, finish; then a done state raises out_valid.
// Reset: rst synchronous, active high; clears the key and the handshake.
// ---------------------------------------------------------------------------
// mailbox_hmac_sha256_verify_unit
// HMAC-SHA256 check of one mailbox request against its claimed tag.
// ---------------------------------------------------------------------------
module mailbox_hmac_sha256_verify_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mhv_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [63:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 source_id,
  input  logic [31:0]                 message_kind,
  input  logic [31:0]                 payload_word,
  input  logic [31:0]                 sequence_count,
  input  logic [63:0]                 given_tag_0,
  input  logic [63:0]                 given_tag_1,
  input  logic [63:0]                 given_tag_2,
  input  logic [63:0]                 given_tag_3,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [63:0]                 computed_tag_0,
  output logic [63:0]                 computed_tag_1,
  output logic [63:0]                 computed_tag_2,
  output logic [63:0]                 computed_tag_3,
  output logic                        tag_ok
);

  mhv_pkg::mhv_cmd_t cmd;
  logic [255:0]      tag;

  mhv_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );

  mhv_datapath u_dp (
    .clk, .rst, .cmd, .cfg_we, .cfg_idx, .cfg_data,
    .msg   ({source_id, message_kind, payload_word, sequence_count}),
    .given ({given_tag_0, given_tag_1, given_tag_2, given_tag_3}),
    .tag,
    .ok    (tag_ok)
  );

  assign computed_tag_0 = tag[255:192];
  assign computed_tag_1 = tag[191:128];
  assign computed_tag_2 = tag[127:64];
  assign computed_tag_3 = tag[63:0];

endmodule

>>> verif/tb_mailbox_hmac_sha256_verify_unit.sv
// ---------------------------------------------------------------------------
// tb_mailbox_hmac_sha256_verify_unit
// Drives mailbox requests through the HMAC-SHA256 verify unit under several
// key settings. A local SHA-256 model predicts each computed tag and the
// match flag. Every result is checked in order against those predictions.
// ---------------------------------------------------------------------------
module tb_mailbox_hmac_sha256_verify_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned SettleCycles = 8;

  typedef enum logic {REQ_MSG, REQ_KEY_WRITE} req_kind_t;

  typedef struct {
    req_kind_t                    kind;
    logic [mhv_pkg::CfgIdxW-1:0]  idx;
    logic [63:0]                  data;
    logic [127:0]                 msg;
    logic [255:0]                 given;
  } mbox_req_t;

  typedef struct {
    logic [255:0] tag;
    logic         ok;
  } tag_result_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [255:0] SHA_IV = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [mhv_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] source_id = '0, message_kind = '0, payload_word = '0, sequence_count = '0;
  logic [63:0] given_tag_0 = '0, given_tag_1 = '0, given_tag_2 = '0, given_tag_3 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] computed_tag_0, computed_tag_1, computed_tag_2, computed_tag_3;
  logic tag_ok;

  mbox_req_t   pending_reqs [$];
  tag_result_t expected_tags [$];
  logic [255:0] dut_key = '0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  mailbox_hmac_sha256_verify_unit u_top (.*);

  always #1 clk = ~clk;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of a 512-bit block into a chaining value.
  function automatic logic [255:0] sha_compress(logic [255:0] h, logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    logic [255:0] res;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = h[255 - 32*i -: 32];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) res[255 - 32*i -: 32] = h[255 - 32*i -: 32] + v[i];
    return res;
  endfunction

  // HMAC-SHA256 of a 16-byte message under a 32-byte key padded with zeros.
  function automatic logic [255:0] hmac_tag(logic [255:0] key, logic [127:0] msg);
    logic [255:0] inner, outer;
    inner = sha_compress(SHA_IV, {key ^ {8{mhv_pkg::IpadWord}}, {8{mhv_pkg::IpadWord}}});
    inner = sha_compress(inner, {msg, mhv_pkg::PadBit, 320'b0, mhv_pkg::InnerLen});
    outer = sha_compress(SHA_IV, {key ^ {8{mhv_pkg::OpadWord}}, {8{mhv_pkg::OpadWord}}});
    return sha_compress(outer, {inner, mhv_pkg::PadBit, 192'b0, mhv_pkg::OuterLen});
  endfunction

  function automatic void queue_key(logic [255:0] key);
    mbox_req_t r;
    r = '{kind: REQ_KEY_WRITE, idx: mhv_pkg::RegKey0, data: key[255:192], msg: '0,
          given: '0};
    pending_reqs.push_back(r);
    r.idx = mhv_pkg::RegKey1; r.data = key[191:128]; pending_reqs.push_back(r);
    r.idx = mhv_pkg::RegKey2; r.data = key[127:64];  pending_reqs.push_back(r);
    r.idx = mhv_pkg::RegKey3; r.data = key[63:0];    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_msg(logic [127:0] msg, logic [255:0] given);
    mbox_req_t r;
    r = '{kind: REQ_MSG, idx: '0, data: '0, msg: msg, given: given};
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [255:0] rand256();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Half genuine tags with random content, the rest one-bit forgeries and noise.
  function automatic void queue_random_msgs(logic [255:0] key, int unsigned n);
    logic [127:0] msg;
    logic [255:0] tag;
    for (int i = 0; i < n; i++) begin
      msg = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(9) == 0) msg[32*$urandom_range(3) +: 32] = {32{msg[0]}};
      tag = hmac_tag(key, msg);
      case ($urandom_range(7))
        0, 1: tag = rand256();
        2, 3: tag[$urandom_range(255)] ^= 1'b1;
        default: ;
      endcase
      queue_msg(msg, tag);
    end
  endfunction

  // Stimulus plan: directed requests, then random phases under several keys.
  initial begin
    logic [255:0] key;
    logic [255:0] t;
    key = '0;
    queue_msg('0, '0);
    queue_msg('1, '1);
    t = hmac_tag(key, '0);
    queue_msg('0, t);
    queue_msg('0, t ^ {1'b1, 255'b0});
    queue_msg('0, t ^ 256'b1);
    t = hmac_tag(key, '1);
    queue_msg('1, t);
    queue_msg(128'h80000000_00000001_7fffffff_fffffffe, '0);
    key = '1;
    queue_key(key);
    queue_msg('0, hmac_tag(key, '0));
    queue_msg('1, hmac_tag(key, '1));
    queue_msg('1, '0);
    t = hmac_tag(key, 128'h01234567_89abcdef_fedcba98_76543210);
    queue_msg(128'h01234567_89abcdef_fedcba98_76543210, t);
    queue_msg(128'h01234567_89abcdef_fedcba98_76543210, t ^ {128'b0, 1'b1, 127'b0});
    queue_random_msgs(key, 150);
    key = rand256();
    queue_key(key);
    queue_random_msgs(key, 180);
    key = '0;
    queue_key(key);
    queue_random_msgs(key, 170);
    key = {8{32'haaaa5555}};
    queue_key(key);
    queue_random_msgs(key, 170);
    key = rand256();
    queue_key(key);
    queue_random_msgs(key, 170);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !in_valid && expected_tags.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_tags.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Request driver: bursts with random gaps; key writes wait for an idle unit.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    logic vld;
    logic we;
    mbox_req_t r;
    if (!rst) begin
      vld = in_valid;
      we = 1'b0;
      if (in_valid && !in_stall) begin
        expected_tags.push_back('{tag: hmac_tag(dut_key,
            {source_id, message_kind, payload_word, sequence_count}),
          ok: hmac_tag(dut_key, {source_id, message_kind, payload_word, sequence_count})
              == {given_tag_0, given_tag_1, given_tag_2, given_tag_3}});
        vld = 1'b0;
      end
      idle_cycles <= (expected_tags.size() == 0 && !in_valid) ? idle_cycles + 1 : 0;
      if (!vld && pending_reqs.size() > 0) begin
        r = pending_reqs[0];
        if (r.kind == REQ_KEY_WRITE) begin
          if (idle_cycles >= SettleCycles) begin
            we = 1'b1;
            cfg_idx <= r.idx;
            cfg_data <= r.data;
            dut_key[255 - 64*r.idx -: 64] = r.data;
            void'(pending_reqs.pop_front());
          end
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          vld = 1'b1;
          {source_id, message_kind, payload_word, sequence_count} <= r.msg;
          {given_tag_0, given_tag_1, given_tag_2, given_tag_3} <= r.given;
          void'(pending_reqs.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 6);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 400);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_valid <= vld;
      cfg_we <= we;
    end
  end

  // Result monitor with its own stall pattern, changing mode every so often.
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    tag_result_t e;
    logic [255:0] got;
    if (!rst) begin
      if (cycle_count % 500 == 0) stall_mode <= $urandom_range(3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        2: out_stall <= ($urandom_range(3) != 0);
        default: out_stall <= ((cycle_count / 37) % 2 == 1);
      endcase
      if (out_valid && !out_stall) begin
        got = {computed_tag_0, computed_tag_1, computed_tag_2, computed_tag_3};
        if (expected_tags.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result: tag %h ok %b", got, tag_ok);
        end else begin
          e = expected_tags.pop_front();
          if (got !== e.tag || tag_ok !== e.ok) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("result mismatch: expected tag %h ok %b", e.tag, e.ok);
              $display("                 actual   tag %h ok %b", got, tag_ok);
            end
          end
        end
      end
    end
  end

endmodule
